>>> rtl/ufbd_pkg.sv
// ----------------------------------------------------------------------------
// ufbd_pkg: shared types and constants for the UART fractional baud divider
// Field widths, divider limits, and the command/status bundles that pass
// between the sequencer and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ufbd_pkg;

  // Field widths
  localparam int CLK_W  = 28;
  localparam int BAUD_W = 24;
  localparam int DIV_W  = 16;
  localparam int FRAC_W = 4;

  // 16x oversampling: clock/16 is a 4-bit shift
  localparam int OVS_SHIFT = 4;

  // Quotient of (clock/16)/baud, one bit per divide step
  localparam int QUO_W   = CLK_W - OVS_SHIFT;
  localparam int STEP_W  = $clog2(QUO_W);

  // Reduced denominator i*(mul+add): 16-bit divisor times a 5-bit sum
  localparam int SUM_W  = FRAC_W + 1;
  localparam int DEN_W  = DIV_W + SUM_W;
  // 16*den*baud and clock*mul before the difference
  localparam int XP_W   = DEN_W + BAUD_W;
  localparam int X_W    = XP_W + OVS_SHIFT;
  localparam int Y_W    = CLK_W + FRAC_W;
  // Error numerator is below 2^34 for every candidate; two bits of margin
  localparam int NUM_W  = 36;
  localparam int PROD_W = NUM_W + DEN_W;

  localparam logic [DIV_W-1:0]  DIV_MAX   = '1;
  localparam logic [DIV_W-1:0]  DIV_ONE   = DIV_W'(1);
  localparam logic [FRAC_W-1:0] FRAC_ZERO = '0;
  localparam logic [FRAC_W-1:0] FRAC_ONE  = FRAC_W'(1);
  localparam logic [FRAC_W-1:0] FRAC_TWO  = FRAC_W'(2);
  localparam logic [CLK_W-1:0]  CLK_RESET = CLK_W'(60000000);

  localparam int FRAC_LIMIT_DEF = 16;

  // Divisor offset of a candidate relative to the base divisor
  typedef enum logic [1:0] {
    OFF_DN  = 2'd0,
    OFF_MID = 2'd1,
    OFF_UP  = 2'd2
  } offset_t;

  // Sequencer to datapath
  typedef struct packed {
    logic                 load;      // capture baud, start division
    logic                 div_step;  // one restoring-division step
    logic                 check;     // latch base divisor and exact flag
    logic                 issue;     // launch one candidate into the pipe
    logic                 init;      // candidate seeds the best-so-far
    offset_t              off;
    logic [FRAC_W-1:0]    frac_add;
    logic [FRAC_W-1:0]    frac_mul;
  } cmd_t;

  // Datapath to sequencer
  typedef struct packed {
    logic exact;    // quotient alone hits the rate (valid during check)
    logic div_min;  // base divisor is 1, no lower neighbor
    logic div_max;  // base divisor is saturated, no upper neighbor
  } status_t;

endpackage

`default_nettype wire

>>> rtl/ufbd_ctrl.sv
// ----------------------------------------------------------------------------
// ufbd_ctrl: sequencer for the baud divider search
// Runs the division steps, then walks the candidate list (divisor offset,
// mul, add) and launches each candidate into the datapath, with a gap between.
// ----------------------------------------------------------------------------
`default_nettype none

module ufbd_ctrl #(
  parameter int FRAC_LIMIT = ufbd_pkg::FRAC_LIMIT_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  output logic                   done,
  output ufbd_pkg::cmd_t         cmd,
  input  wire ufbd_pkg::status_t st
);
  import ufbd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_CHECK,
    S_BASE,
    S_SEARCH,
    S_DRAIN
  } state_t;

  localparam logic [FRAC_W-1:0] LAST_M   = FRAC_W'(FRAC_LIMIT - 1);
  localparam logic [STEP_W-1:0] LAST_STP = STEP_W'(QUO_W - 1);
  localparam logic [1:0]        LAST_DRN = 2'd2;
  localparam bit                HAS_FRAC = (FRAC_LIMIT > 2);

  state_t            state;
  logic [STEP_W-1:0] step_cnt;
  logic [1:0]        drain_cnt;
  logic              gap;
  offset_t           off;
  logic [FRAC_W-1:0] m;
  logic [FRAC_W-1:0] a;

  logic    last_a;
  logic    last_m;
  logic    last_cand;
  offset_t end_off;
  offset_t start_off;
  offset_t off_inc;

  assign busy = (state != S_IDLE);

  // candidate walk bounds
  assign end_off   = st.div_max ? OFF_MID : OFF_UP;
  assign start_off = st.div_min ? OFF_MID : OFF_DN;
  assign last_a    = (a == m - FRAC_ONE);
  assign last_m    = (m == LAST_M);
  assign last_cand = last_a && last_m && (off == end_off);

  always_comb begin
    unique case (off)
      OFF_DN:  off_inc = OFF_MID;
      OFF_MID: off_inc = OFF_UP;
      default: off_inc = OFF_UP;
    endcase
  end

  // commands to the datapath
  always_comb begin
    cmd.load     = (state == S_IDLE) && start;
    cmd.div_step = (state == S_DIV);
    cmd.check    = (state == S_CHECK);
    cmd.init     = (state == S_BASE);
    cmd.issue    = (state == S_BASE) || ((state == S_SEARCH) && !gap);
    cmd.off      = (state == S_BASE) ? OFF_MID : off;
    cmd.frac_add = (state == S_BASE) ? FRAC_ZERO : a;
    cmd.frac_mul = (state == S_BASE) ? FRAC_ONE : m;
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      step_cnt  <= '0;
      drain_cnt <= '0;
      gap       <= 1'b0;
      off       <= OFF_DN;
      m         <= FRAC_TWO;
      a         <= FRAC_ONE;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state    <= S_DIV;
            step_cnt <= '0;
          end
        end
        S_DIV: begin
          step_cnt <= step_cnt + STEP_W'(1);
          if (step_cnt == LAST_STP) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (st.exact) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end else begin
            state <= S_BASE;
          end
        end
        S_BASE: begin
          gap       <= 1'b1;
          off       <= start_off;
          m         <= FRAC_TWO;
          a         <= FRAC_ONE;
          drain_cnt <= '0;
          state     <= HAS_FRAC ? S_SEARCH : S_DRAIN;
        end
        S_SEARCH: begin
          gap <= !gap;
          if (!gap) begin
            if (last_cand) begin
              state     <= S_DRAIN;
              drain_cnt <= '0;
            end else if (last_a) begin
              a <= FRAC_ONE;
              if (last_m) begin
                m   <= FRAC_TWO;
                off <= off_inc;
              end else begin
                m <= m + FRAC_ONE;
              end
            end else begin
              a <= a + FRAC_ONE;
            end
          end
        end
        S_DRAIN: begin
          drain_cnt <= drain_cnt + 2'd1;
          if (drain_cnt == LAST_DRN) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/ufbd_dp.sv
// ----------------------------------------------------------------------------
// ufbd_dp: datapath for the baud divider search
// Clock register, bit-serial divider for the base divisor, and a four-stage
// candidate pipe that scores each divisor/fraction by exact cross-multiplied
// relative error and keeps the first strictly better one.
// ----------------------------------------------------------------------------
`default_nettype none

module ufbd_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [ufbd_pkg::CLK_W-1:0]    cfg_wdata,
  input  wire logic [ufbd_pkg::BAUD_W-1:0]   baud_rate,
  input  wire ufbd_pkg::cmd_t                cmd,
  output ufbd_pkg::status_t                  st,
  output logic [ufbd_pkg::DIV_W-1:0]         divisor,
  output logic [ufbd_pkg::FRAC_W-1:0]        frac_add,
  output logic [ufbd_pkg::FRAC_W-1:0]        frac_mul,
  output logic                               exact_match
);
  import ufbd_pkg::*;

  // configuration
  logic [CLK_W-1:0]  clk_hz;

  // division
  logic [BAUD_W-1:0] baud_r;
  logic [QUO_W-1:0]  quo;
  logic [BAUD_W-1:0] rem;
  logic [BAUD_W:0]   rem_sh;
  logic              rem_ge;
  logic [DIV_W-1:0]  d_calc;
  logic [DIV_W-1:0]  d_r;

  // stage 1
  logic              v1;
  logic              init1;
  logic [DIV_W-1:0]  i1;
  logic [FRAC_W-1:0] a1;
  logic [FRAC_W-1:0] m1;
  logic [DEN_W-1:0]  dp1;
  logic [Y_W-1:0]    y1;
  logic [DIV_W-1:0]  i_c;
  logic [SUM_W-1:0]  s_c;
  logic [DEN_W-1:0]  dp_c;
  logic [Y_W-1:0]    y_c;

  // stage 2
  logic              v2;
  logic              init2;
  logic [DIV_W-1:0]  i2;
  logic [FRAC_W-1:0] a2;
  logic [FRAC_W-1:0] m2;
  logic [DEN_W-1:0]  dp2;
  logic [NUM_W-1:0]  num2;
  logic [XP_W-1:0]   xp_c;
  logic [X_W-1:0]    x_c;
  logic [X_W-1:0]    yx_c;
  logic [X_W-1:0]    diff_c;

  // stage 3
  logic              v3;
  logic              init3;
  logic [DIV_W-1:0]  i3;
  logic [FRAC_W-1:0] a3;
  logic [FRAC_W-1:0] m3;
  logic [DEN_W-1:0]  dp3;
  logic [NUM_W-1:0]  num3;
  logic [PROD_W-1:0] pa3;
  logic [PROD_W-1:0] pb3;
  logic [PROD_W-1:0] pa_c;
  logic [PROD_W-1:0] pb_c;

  // best so far
  logic [NUM_W-1:0]  best_num;
  logic [DEN_W-1:0]  best_dp;
  logic [DIV_W-1:0]  best_div;
  logic [FRAC_W-1:0] best_add;
  logic [FRAC_W-1:0] best_mul;
  logic              exact_r;

  // clock frequency register
  always_ff @(posedge clk) begin
    if (rst) begin
      clk_hz <= CLK_RESET;
    end else if (cfg_write) begin
      clk_hz <= cfg_wdata;
    end
  end

  // restoring divide of clock/16 by baud, one quotient bit per step
  assign rem_sh = {rem, quo[QUO_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, baud_r});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      baud_r <= (baud_rate == '0) ? BAUD_W'(1) : baud_rate;
      quo    <= clk_hz[CLK_W-1:OVS_SHIFT];
      rem    <= '0;
    end else if (cmd.div_step) begin
      rem <= rem_ge ? BAUD_W'(rem_sh - {1'b0, baud_r}) : rem_sh[BAUD_W-1:0];
      quo <= {quo[QUO_W-2:0], rem_ge};
    end
  end

  // base divisor: at least one, saturated at the 16-bit limit
  always_comb begin
    if (quo == '0) begin
      d_calc = DIV_ONE;
    end else if (quo[QUO_W-1:DIV_W] != '0) begin
      d_calc = DIV_MAX;
    end else begin
      d_calc = quo[DIV_W-1:0];
    end
  end

  assign st.exact   = (quo != '0) && (quo[QUO_W-1:DIV_W] == '0) && (rem == '0)
                      && (clk_hz[OVS_SHIFT-1:0] == '0);
  assign st.div_min = (d_r == DIV_ONE);
  assign st.div_max = (d_r == DIV_MAX);

  // stage 1: candidate divisor, reduced denominator, clock*mul
  always_comb begin
    unique case (cmd.off)
      OFF_DN:  i_c = d_r - DIV_ONE;
      OFF_MID: i_c = d_r;
      OFF_UP:  i_c = d_r + DIV_ONE;
      default: i_c = d_r;
    endcase
  end

  assign s_c  = {1'b0, cmd.frac_mul} + {1'b0, cmd.frac_add};
  assign dp_c = i_c * s_c;
  assign y_c  = clk_hz * cmd.frac_mul;

  // stage 2: error numerator |16*den*baud - clock*mul|
  assign xp_c   = dp1 * baud_r;
  assign x_c    = {xp_c, {OVS_SHIFT{1'b0}}};
  assign yx_c   = X_W'(y1);
  assign diff_c = (x_c >= yx_c) ? (x_c - yx_c) : (yx_c - x_c);

  // stage 3: cross products against the current best
  assign pa_c = num2 * best_dp;
  assign pb_c = best_num * dp2;

  // pipe valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // pipe payload
  always_ff @(posedge clk) begin
    init1 <= cmd.init;
    i1    <= i_c;
    a1    <= cmd.frac_add;
    m1    <= cmd.frac_mul;
    dp1   <= dp_c;
    y1    <= y_c;

    init2 <= init1;
    i2    <= i1;
    a2    <= a1;
    m2    <= m1;
    dp2   <= dp1;
    num2  <= diff_c[NUM_W-1:0];

    init3 <= init2;
    i3    <= i2;
    a3    <= a2;
    m3    <= m2;
    dp3   <= dp2;
    num3  <= num2;
    pa3   <= pa_c;
    pb3   <= pb_c;
  end

  // stage 4: seed on check, then keep the first strictly better candidate
  always_ff @(posedge clk) begin
    if (cmd.check) begin
      d_r      <= d_calc;
      exact_r  <= st.exact;
      best_div <= d_calc;
      best_add <= FRAC_ZERO;
      best_mul <= FRAC_ONE;
    end else if (v3 && (init3 || (pa3 < pb3))) begin
      best_num <= num3;
      best_dp  <= dp3;
      best_div <= i3;
      best_add <= a3;
      best_mul <= m3;
    end
  end

  assign divisor     = best_div;
  assign frac_add    = best_add;
  assign frac_mul    = best_mul;
  assign exact_match = exact_r;

endmodule

`default_nettype wire

>>> rtl/uart_fractional_baud_divider_search.sv
// ----------------------------------------------------------------------------
// uart_fractional_baud_divider_search: UART divisor and fraction finder
// Finds the 16x-oversampled divisor and the add/mul fraction that best match
// a requested baud rate from the configured peripheral clock.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_write/cfg_wdata load the peripheral clock in Hz (reset 60 MHz);
//   write it only while busy is low.
//   A request transfer happens at a clock edge with start high and busy low;
//   baud_rate is sampled there. busy stays high until the result is shown.
//   The result (divisor, frac_add, frac_mul, exact_match) is valid for the
//   one cycle that done is high; the receiver cannot stall it, so it must
//   take the transfer in that cycle. busy is low during the done cycle.
// Sequence, from the request edge through the done cycle:
//   when the plain divisor is exact: 24 restoring-divide steps, one bit per
//   cycle, then the check state and the done cycle itself.
//   Otherwise the base candidate and K = n*(L-1)*(L-2)/2 fraction candidates
//   over n = 3 neighbor divisors (2 at the divisor limits), L = FRAC_LIMIT,
//   are scored and the pipe drains. The next candidate enters the pipe before
//   the last has left it, with a gap between launches, set by the best-error
//   feedback through the cross-product multipliers. One request at a time.
// Reset clears the sequencer and the pipe valid bits; the clock register
// returns to its reset value.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_fractional_baud_divider_search #(
  parameter int FRAC_LIMIT = ufbd_pkg::FRAC_LIMIT_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_write,
  input  wire logic [ufbd_pkg::CLK_W-1:0]  cfg_wdata,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [ufbd_pkg::BAUD_W-1:0] baud_rate,
  output logic                             done,
  output logic [ufbd_pkg::DIV_W-1:0]       divisor,
  output logic [ufbd_pkg::FRAC_W-1:0]      frac_add,
  output logic [ufbd_pkg::FRAC_W-1:0]      frac_mul,
  output logic                             exact_match
);
  import ufbd_pkg::*;

  cmd_t    cmd;
  status_t st;

  // sequencer
  ufbd_ctrl #(
    .FRAC_LIMIT(FRAC_LIMIT)
  ) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .st    (st)
  );

  // datapath
  ufbd_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_wdata   (cfg_wdata),
    .baud_rate   (baud_rate),
    .cmd         (cmd),
    .st          (st),
    .divisor     (divisor),
    .frac_add    (frac_add),
    .frac_mul    (frac_mul),
    .exact_match (exact_match)
  );

endmodule

`default_nettype wire

>>> rtl/ufbd_checker.sv
// ----------------------------------------------------------------------------
// ufbd_checker: port-level checks for the baud divider search
// Watches the request/result ports of the top level over time; bound in
// below.
// ----------------------------------------------------------------------------
`default_nettype none

module ufbd_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic                        done,
  input wire logic [ufbd_pkg::DIV_W-1:0]  divisor,
  input wire logic [ufbd_pkg::FRAC_W-1:0] frac_add,
  input wire logic [ufbd_pkg::FRAC_W-1:0] frac_mul,
  input wire logic                        exact_match
);
  import ufbd_pkg::*;

  // a request transfer makes the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request transfer did not raise busy");

  // busy drops exactly when a result is shown
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && !$past(rst)) |-> done)
    else $error("busy dropped without a result");

  // result strobe lasts one cycle and never overlaps busy
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy ##1 !done))
    else $error("result strobe overlaps busy or lasts more than one cycle");

  // result fields are a legal divisor and fraction
  a_result_legal: assert property (@(posedge clk) disable iff (rst)
    done |-> ((divisor != '0) && (frac_mul != FRAC_ZERO) && (frac_add < frac_mul)))
    else $error("illegal divisor or fraction");

  // an exact divisor carries no fraction
  a_exact_plain: assert property (@(posedge clk) disable iff (rst)
    (done && exact_match) |-> ((frac_add == FRAC_ZERO) && (frac_mul == FRAC_ONE)))
    else $error("exact result with a fraction");

endmodule

bind uart_fractional_baud_divider_search ufbd_checker u_ufbd_checker (.*);

`default_nettype wire
